FILE: src/mdst_pkg.sv
`default_nettype none

package mdst_pkg;

    // Grid and capacity.
    localparam int GRID_SPAN  = 4096;
    localparam int MAX_POINTS = 65536;

    // Derived widths.
    localparam int ADDR_W = $clog2(GRID_SPAN);
    localparam int PT_W   = 12;
    localparam int CUR_W  = (ADDR_W + 1 > PT_W) ? ADDR_W + 1 : PT_W;
    localparam int CW1    = CUR_W + 1;
    localparam int DW     = CW1 + 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = 40;

    localparam logic signed [CW1-1:0] HALF_C = CW1'(GRID_SPAN / 2);

    // Item kinds.
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    // Move directions.
    localparam logic [1:0] DIR_Y_UP   = 2'd0;
    localparam logic [1:0] DIR_X_UP   = 2'd1;
    localparam logic [1:0] DIR_Y_DOWN = 2'd2;
    localparam logic [1:0] DIR_X_DOWN = 2'd3;

    typedef struct packed {
        logic                   kind;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic [1:0]             direction;
    } req_t;

    typedef struct packed {
        logic [SUM_W-1:0] distance_sum;
        logic             refused;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Histogram address of a grid coordinate.
    function automatic logic [ADDR_W-1:0] cell_addr(logic signed [CW1-1:0] c);
        logic signed [CW1-1:0] s;
        s = c + HALF_C;
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic on_grid(logic signed [CW1-1:0] c);
        return (c >= -HALF_C) && (c < HALF_C);
    endfunction

    // Sign-extend a point coordinate to cursor arithmetic width.
    function automatic logic signed [CW1-1:0] ext_pt(logic signed [PT_W-1:0] p);
        return CW1'(p);
    endfunction

    function automatic logic signed [CW1-1:0] ext_cur(logic signed [CUR_W-1:0] c);
        return CW1'(c);
    endfunction

endpackage

`default_nettype wire

FILE: src/manhattan_distance_sum_tracker.sv
// A request accepted in idle is registered in item_reg with its histogram reads; its response is
// registered when ST_EXEC completes: histogram read at acceptance, read-modify-write in ST_EXEC.
// No request is accepted outside ST_IDLE. A response that is not taken holds the next request
// in ST_EXEC until it is taken. Reset: asynchronous, active low. After reset a clearing pass
// zeroes both histograms, one entry a cycle over all GRID_SPAN entries, with req_ready low.
`default_nettype none

module manhattan_distance_sum_tracker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mdst_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mdst_pkg::rsp_t     rsp
);
    import mdst_pkg::*;

    // Histogram memories.
    logic [CNT_W-1:0] col_mem [GRID_SPAN];
    logic [CNT_W-1:0] row_mem [GRID_SPAN];

    logic [CNT_W-1:0] col_rd_a_reg, col_rd_b_reg;
    logic [CNT_W-1:0] row_rd_a_reg, row_rd_b_reg;

    state_t state_reg, state_next;
    req_t   item_reg, item_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic signed [CUR_W-1:0] cursor_x_reg, cursor_x_next;
    logic signed [CUR_W-1:0] cursor_y_reg, cursor_y_next;
    logic [CNT_W-1:0] count_left_reg, count_left_next;
    logic [CNT_W-1:0] count_right_reg, count_right_next;
    logic [CNT_W-1:0] count_below_reg, count_below_next;
    logic [CNT_W-1:0] count_above_reg, count_above_next;
    logic [CNT_W-1:0] point_total_reg, point_total_next;
    logic [SUM_W-1:0] running_sum_reg, running_sum_next;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic              accept;
    logic              rd_en;
    logic [ADDR_W-1:0] col_ra_a, col_ra_b, row_ra_a, row_ra_b;
    logic              col_we, row_we;
    logic [ADDR_W-1:0] col_wa, row_wa;
    logic [CNT_W-1:0]  col_wd, row_wd;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Read addresses at acceptance: the add point, or the cursor cell and its neighbor.
    always_comb
    begin
        logic signed [CW1-1:0] cx, cy, nx, ny;
        cx = ext_cur(cursor_x_reg);
        cy = ext_cur(cursor_y_reg);
        nx = (req.direction == DIR_X_UP) ? cx + CW1'(1) : cx - CW1'(1);
        ny = (req.direction == DIR_Y_UP) ? cy + CW1'(1) : cy - CW1'(1);
        rd_en = accept;
        if (req.kind == KIND_ADD)
        begin
            col_ra_a = cell_addr(ext_pt(req.point_x));
            row_ra_a = cell_addr(ext_pt(req.point_y));
        end
        else
        begin
            col_ra_a = cell_addr(cx);
            row_ra_a = cell_addr(cy);
        end
        col_ra_b = cell_addr(nx);
        row_ra_b = cell_addr(ny);
    end

    // Next state, execution and memory write control.
    always_comb
    begin
        logic                  exec_go;
        logic signed [CW1-1:0] px, py, cx, cy, cur, nxt;
        logic signed [DW-1:0]  dx, dy;
        logic [SUM_W-1:0]      add_dist;
        logic                  add_ok, axis_x, up, move_ok;
        logic [CNT_W-1:0]      here, there, lo, hi, lo_new, hi_new;
        logic [SUM_W-1:0]      sum_mv;

        state_next       = state_reg;
        item_next        = item_reg;
        clr_cnt_next     = clr_cnt_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        count_left_next  = count_left_reg;
        count_right_next = count_right_reg;
        count_below_next = count_below_reg;
        count_above_next = count_above_reg;
        point_total_next = point_total_reg;
        running_sum_next = running_sum_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;

        exec_go = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

        // Add path.
        px = ext_pt(item_reg.point_x);
        py = ext_pt(item_reg.point_y);
        cx = ext_cur(cursor_x_reg);
        cy = ext_cur(cursor_y_reg);
        dx = DW'(px) - DW'(cx);
        dy = DW'(py) - DW'(cy);
        if (dx[DW-1])
            dx = -dx;
        if (dy[DW-1])
            dy = -dy;
        add_dist = SUM_W'(dx[DW-2:0]) + SUM_W'(dy[DW-2:0]);
        add_ok = (point_total_reg < CNT_W'(MAX_POINTS)) && on_grid(px) && on_grid(py);

        // Move path.
        axis_x = item_reg.direction[0];
        up     = !item_reg.direction[1];
        cur    = axis_x ? cx : cy;
        nxt    = up ? cur + CW1'(1) : cur - CW1'(1);
        move_ok = on_grid(nxt);
        here   = axis_x ? col_rd_a_reg : row_rd_a_reg;
        there  = axis_x ? col_rd_b_reg : row_rd_b_reg;
        lo     = axis_x ? count_left_reg : count_below_reg;
        hi     = axis_x ? count_right_reg : count_above_reg;
        if (up)
        begin
            sum_mv = running_sum_reg + SUM_W'(lo) + SUM_W'(here) - SUM_W'(hi);
            lo_new = lo + here;
            hi_new = hi - there;
        end
        else
        begin
            sum_mv = running_sum_reg + SUM_W'(hi) + SUM_W'(here) - SUM_W'(lo);
            hi_new = hi + here;
            lo_new = lo - there;
        end

        // Memory write defaults: clearing pass.
        col_we = 1'b0;
        row_we = 1'b0;
        col_wa = clr_cnt_reg;
        row_wa = clr_cnt_reg;
        col_wd = '0;
        row_wd = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                col_we       = 1'b1;
                row_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(GRID_SPAN - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    if (item_reg.kind == KIND_ADD)
                    begin
                        rsp_next.refused = !add_ok;
                        rsp_next.distance_sum = running_sum_reg;
                        if (add_ok)
                        begin
                            col_we = 1'b1;
                            row_we = 1'b1;
                            col_wa = cell_addr(px);
                            row_wa = cell_addr(py);
                            col_wd = col_rd_a_reg + CNT_W'(1);
                            row_wd = row_rd_a_reg + CNT_W'(1);
                            point_total_next = point_total_reg + CNT_W'(1);
                            if (px < cx)
                                count_left_next = count_left_reg + CNT_W'(1);
                            if (px > cx)
                                count_right_next = count_right_reg + CNT_W'(1);
                            if (py < cy)
                                count_below_next = count_below_reg + CNT_W'(1);
                            if (py > cy)
                                count_above_next = count_above_reg + CNT_W'(1);
                            running_sum_next = running_sum_reg + add_dist;
                            rsp_next.distance_sum = running_sum_reg + add_dist;
                        end
                    end
                    else
                    begin
                        rsp_next.refused = !move_ok;
                        rsp_next.distance_sum = running_sum_reg;
                        if (move_ok)
                        begin
                            running_sum_next = sum_mv;
                            rsp_next.distance_sum = sum_mv;
                            if (axis_x)
                            begin
                                cursor_x_next    = nxt[CUR_W-1:0];
                                count_left_next  = lo_new;
                                count_right_next = hi_new;
                            end
                            else
                            begin
                                cursor_y_next    = nxt[CUR_W-1:0];
                                count_below_next = lo_new;
                                count_above_next = hi_new;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Column histogram memory.
    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[col_wa] <= col_wd;
        if (rd_en)
        begin
            col_rd_a_reg <= col_mem[col_ra_a];
            col_rd_b_reg <= col_mem[col_ra_b];
        end
    end

    // Row histogram memory.
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_wa] <= row_wd;
        if (rd_en)
        begin
            row_rd_a_reg <= row_mem[row_ra_a];
            row_rd_b_reg <= row_mem[row_ra_b];
        end
    end

    // Control and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            count_left_reg  <= '0;
            count_right_reg <= '0;
            count_below_reg <= '0;
            count_above_reg <= '0;
            point_total_reg <= '0;
            running_sum_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            count_left_reg  <= count_left_next;
            count_right_reg <= count_right_next;
            count_below_reg <= count_below_next;
            count_above_reg <= count_above_next;
            point_total_reg <= point_total_next;
            running_sum_reg <= running_sum_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

FILE: sim/tb_manhattan_distance_sum_tracker.sv
`timescale 1ns / 1ps

module tb_manhattan_distance_sum_tracker;

    import mdst_pkg::*;

    localparam int HALF_SPAN   = GRID_SPAN / 2;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES = 300;

    // One row of the directed table; the expected response is given only where known is set.
    typedef struct packed {
        logic                   kind;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic [1:0]             direction;
        logic                   known;
        logic [SUM_W-1:0]       distance_sum;
        logic                   refused;
    } vector_t;

    localparam int NUM_VECTORS = 17;
    localparam vector_t DIRECTED_VECTORS [NUM_VECTORS] = '{
        // Points added around the cursor at the origin, the grid corners among them.
        '{KIND_ADD,  12'h000, 12'h000, DIR_X_DOWN, 1'b1, 40'd0,    1'b0},
        '{KIND_ADD,  12'h7FF, 12'h7FF, DIR_Y_UP,   1'b1, 40'd4094, 1'b0},
        '{KIND_ADD,  12'h800, 12'h800, DIR_X_UP,   1'b1, 40'd8190, 1'b0},
        '{KIND_ADD,  12'hFFF, 12'h001, DIR_Y_DOWN, 1'b1, 40'd8192, 1'b0},
        // Steps in all four directions.
        '{KIND_MOVE, 12'h555, 12'hAAA, DIR_Y_UP,   1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'hAAA, 12'h555, DIR_X_UP,   1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'hFFF, 12'h000, DIR_Y_DOWN, 1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'h000, 12'hFFF, DIR_X_DOWN, 1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'h123, 12'hEDC, DIR_X_DOWN, 1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'hEDC, 12'h123, DIR_Y_DOWN, 1'b0, 40'd0,    1'b0},
        // Adds after moves, one of them on the cursor cell.
        '{KIND_ADD,  12'hFFF, 12'hFFF, DIR_Y_UP,   1'b0, 40'd0,    1'b0},
        '{KIND_ADD,  12'h001, 12'hFFF, DIR_X_UP,   1'b0, 40'd0,    1'b0},
        '{KIND_ADD,  12'h7FF, 12'h800, DIR_Y_DOWN, 1'b0, 40'd0,    1'b0},
        '{KIND_ADD,  12'h800, 12'h7FF, DIR_X_DOWN, 1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'h3C3, 12'hC3C, DIR_Y_UP,   1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'hC3C, 12'h3C3, DIR_X_UP,   1'b0, 40'd0,    1'b0},
        '{KIND_MOVE, 12'h0F0, 12'hF0F, DIR_X_UP,   1'b0, 40'd0,    1'b0}
    };

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_item;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_item;

    // Shared control between the request and response sides.
    bit idle_on;
    bit hold_request;
    int mismatch_count;

    // Predicted tracker state.
    int               cursor_x;
    int               cursor_y;
    int               pts_left;
    int               pts_right;
    int               pts_below;
    int               pts_above;
    int               pts_stored;
    logic [SUM_W-1:0] dist_sum;
    int               column_count [GRID_SPAN];
    int               row_count [GRID_SPAN];

    rsp_t expected_sums [$];

    manhattan_distance_sum_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // One cursor step along an axis; returns 0 when the step would leave the grid.
    function automatic bit walk_axis(inout int pos, inout int below_n, inout int above_n,
                                     input bit along_x, input bit upward);
        int next_pos;
        int here_n;
        int there_n;
        next_pos = upward ? pos + 1 : pos - 1;
        if (next_pos < -HALF_SPAN || next_pos >= HALF_SPAN)
        begin
            return 1'b0;
        end
        here_n  = along_x ? column_count[pos + HALF_SPAN] : row_count[pos + HALF_SPAN];
        there_n = along_x ? column_count[next_pos + HALF_SPAN]
                          : row_count[next_pos + HALF_SPAN];
        if (upward)
        begin
            dist_sum = dist_sum + SUM_W'(below_n) + SUM_W'(here_n) - SUM_W'(above_n);
            below_n += here_n;
            above_n -= there_n;
        end
        else
        begin
            dist_sum = dist_sum + SUM_W'(above_n) + SUM_W'(here_n) - SUM_W'(below_n);
            above_n += here_n;
            below_n -= there_n;
        end
        pos = next_pos;
        return 1'b1;
    endfunction

    // Applies one request to the predicted state and returns the response it should produce.
    function automatic rsp_t track_request(input req_t r);
        rsp_t resp;
        int   px;
        int   py;
        bit   moved;
        resp.refused = 1'b0;
        if (r.kind == KIND_ADD)
        begin
            px = int'(r.point_x);
            py = int'(r.point_y);
            if (pts_stored >= MAX_POINTS || px < -HALF_SPAN || px >= HALF_SPAN
                || py < -HALF_SPAN || py >= HALF_SPAN)
            begin
                resp.refused = 1'b1;
            end
            else
            begin
                column_count[px + HALF_SPAN]++;
                row_count[py + HALF_SPAN]++;
                pts_stored++;
                if (px < cursor_x) pts_left++;
                if (px > cursor_x) pts_right++;
                if (py < cursor_y) pts_below++;
                if (py > cursor_y) pts_above++;
                dist_sum = dist_sum + SUM_W'(px > cursor_x ? px - cursor_x : cursor_x - px)
                                    + SUM_W'(py > cursor_y ? py - cursor_y : cursor_y - py);
            end
        end
        else
        begin
            case (r.direction)
                DIR_Y_UP:   moved = walk_axis(cursor_y, pts_below, pts_above, 1'b0, 1'b1);
                DIR_X_UP:   moved = walk_axis(cursor_x, pts_left, pts_right, 1'b1, 1'b1);
                DIR_Y_DOWN: moved = walk_axis(cursor_y, pts_below, pts_above, 1'b0, 1'b0);
                default:    moved = walk_axis(cursor_x, pts_left, pts_right, 1'b1, 1'b0);
            endcase
            resp.refused = !moved;
        end
        resp.distance_sum = dist_sum;
        return resp;
    endfunction

    // Random request: half adds, spread over the grid or close to the cursor, half moves.
    function automatic req_t random_request();
        req_t r;
        r.kind      = $urandom_range(1) ? KIND_MOVE : KIND_ADD;
        r.point_x   = PT_W'($urandom);
        r.point_y   = PT_W'($urandom);
        r.direction = 2'($urandom);
        if (r.kind == KIND_ADD && $urandom_range(9) < 3)
        begin
            r.point_x = PT_W'(cursor_x + int'($urandom_range(6)) - 3);
            r.point_y = PT_W'(cursor_y + int'($urandom_range(6)) - 3);
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 40)
        begin
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Offers one request from a falling edge and returns at the falling edge after acceptance.
    task automatic push_request(input req_t r, input bit known, input rsp_t typed);
        rsp_t predicted;
        while (idle_on && $urandom_range(99) < 14)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_item  <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        predicted = track_request(r);
        expected_sums.push_back(known ? typed : predicted);
        @(negedge clk);
    endtask

    // Response side: random stalls, plus a long hold-off when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= !(idle_on && $urandom_range(99) < 14);
            end
        end
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge clk)
    begin : check_response
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                flag_mismatch("unexpected response, distance_sum", rsp_item.distance_sum, 0);
            end
            else
            begin
                want = expected_sums.pop_front();
                if (rsp_item.distance_sum !== want.distance_sum)
                begin
                    flag_mismatch("distance_sum", rsp_item.distance_sum, want.distance_sum);
                end
                if (rsp_item.refused !== want.refused)
                begin
                    flag_mismatch("refused", rsp_item.refused, want.refused);
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("tb_manhattan_distance_sum_tracker: FAIL");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        req_t    r;
        rsp_t    typed;
        vector_t v;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_item       = '0;
        idle_on        = 1'b1;
        hold_request   = 1'b0;
        mismatch_count = 0;
        cursor_x       = 0;
        cursor_y       = 0;
        pts_left       = 0;
        pts_right      = 0;
        pts_below      = 0;
        pts_above      = 0;
        pts_stored     = 0;
        dist_sum       = '0;
        for (int i = 0; i < GRID_SPAN; i++)
        begin
            column_count[i] = 0;
            row_count[i]    = 0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            v = DIRECTED_VECTORS[i];
            r.kind             = v.kind;
            r.point_x          = v.point_x;
            r.point_y          = v.point_y;
            r.direction        = v.direction;
            typed.distance_sum = v.distance_sum;
            typed.refused      = v.refused;
            push_request(r, v.known, typed);
        end

        // Mixed random traffic, with one long stall on the response side
        // and a later stretch without any idling.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 150)
            begin
                hold_request = 1'b1;
            end
            if (i == 300)
            begin
                idle_on = 1'b0;
            end
            if (i == 400)
            begin
                idle_on = 1'b1;
            end
            push_request(random_request(), 1'b0, '0);
        end

        req_valid <= 1'b0;
        while (expected_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_manhattan_distance_sum_tracker: PASS");
        end
        else
        begin
            $display("tb_manhattan_distance_sum_tracker: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/mdst_pkg.sv
src/manhattan_distance_sum_tracker.sv
sim/tb_manhattan_distance_sum_tracker.sv
